>>> src/euler_to_quaternion_assert.svh
// Assertion macros used by the converter RTL.
`ifndef EULER_TO_QUATERNION_ASSERT_SVH
`define EULER_TO_QUATERNION_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define E2Q_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("e2q assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define E2Q_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("e2q assertion failed");

`endif

>>> src/e2q_pkg.sv
// Package with the fixed-point constants, series tables and types of the converter.
`default_nettype none

package e2q_pkg;

   // Internal Q2.30 format.
   localparam int          Q30_FRAC     = 30;
   localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [31:0] HALF_PI_Q30  = 32'd1686629713;

   // Series and lane organization: lane 2a is the sine, lane 2a+1 the cosine of angle a.
   localparam int SERIES_STEPS = 10;
   localparam int ANGLES       = 3;
   localparam int LANES        = 6;
   localparam int ACC_W        = 34;
   localparam int PROD_W       = 64;

   // Divisors k*(k+1) of each series step and their truncated reciprocals 2^32/d.
   localparam logic [8:0] SIN_DIV [SERIES_STEPS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};
   localparam logic [8:0] COS_DIV [SERIES_STEPS] = '{
      9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306, 9'd380};
   localparam logic [31:0] SIN_RCP [SERIES_STEPS] = '{
      32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323, 32'd39045157,
      32'd27531841, 32'd20452225, 32'd15790320, 32'd12558383, 32'd10226112};
   localparam logic [31:0] COS_RCP [SERIES_STEPS] = '{
      32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844, 32'd47721858,
      32'd32537631, 32'd23598721, 32'd17895697, 32'd14035840, 32'd11302545};

   // Side data that travels with the series terms through every step.
   typedef struct packed {
      logic [LANES-1:0][ACC_W-1:0] acc;
      logic [ANGLES-1:0][31:0]     r2;
      logic [ANGLES-1:0]           ang_neg;
      logic [ANGLES-1:0]           cos_neg;
   } e2q_carry_type;

   // Sign and magnitude of a Q30 value.
   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } e2q_sm_type;

endpackage

`default_nettype wire

>>> src/euler_to_quaternion.sv
// Pipelined Euler-angle to unit-quaternion converter.
//
//  channel  direction  tdata fields (lowest bits first)             tuser/tlast
//  req_     in         heading_angle, attitude_angle, bank_angle    none
//  rsp_     out        quat_w, quat_x, quat_y, quat_z               none
//
// One transaction is accepted per cycle while rsp_tready does not hold the pipeline.
// The pipeline depth is set by the ten-step sine/cosine series, three register stages per step
// (term multiply, reciprocal multiply, quotient correction and accumulate).
// Reset clears only the stage valid bits; the datapath registers carry no reset.
// When a result waits on rsp_tready, the whole pipeline holds and req_tready drops.
`default_nettype none

module euler_to_quaternion
   import e2q_pkg::*;
#(
   parameter int ANGLE_WIDTH = 16,
   parameter int QUAT_WIDTH  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // heading_angle, attitude_angle, bank_angle, zero fill
   input  wire logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // quat_w, quat_x, quat_y, quat_z, zero fill
   output logic [((4*QUAT_WIDTH+7)/8)*8-1:0] rsp_tdata
);

`include "euler_to_quaternion_assert.svh"

   localparam int OUT_BITS  = 4*QUAT_WIDTH;
   localparam int OUT_W     = ((OUT_BITS+7)/8)*8;
   localparam int ANG_SHIFT = 32 - ANGLE_WIDTH;
   localparam int OUT_SHIFT = 32 - QUAT_WIDTH;
   localparam int DEPTH     = 42;
   localparam logic [35:0] OUT_HALF  = (OUT_SHIFT > 0) ? (36'd1 << (OUT_SHIFT-1)) : 36'd0;
   localparam logic [35:0] OUT_LIMIT = 36'd1 << (QUAT_WIDTH-2);
   localparam logic signed [QUAT_WIDTH:0] OUT_LIM_S = (QUAT_WIDTH+1)'(1) << (QUAT_WIDTH-2);

   // Pipeline control: every stage moves when the output register is free or drained.
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic             adv;

   assign adv        = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign vld_in     = {vld_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 1: magnitude of each angle, halved into Q30, folded to [0, pi/2].
   logic [ANGLE_WIDTH-1:0] ang_v   [ANGLES];
   logic [ANGLE_WIDTH-1:0] ang_mag [ANGLES];
   logic [31:0]            ang_m   [ANGLES];
   logic [31:0]            r_in    [ANGLES];
   logic [ANGLES-1:0]      neg_in, cneg_in;
   logic [31:0]            r_ff    [ANGLES];
   logic [ANGLES-1:0]      neg1_ff, cneg1_ff;

   always_comb begin
      for (int a = 0; a < ANGLES; a++) begin
         ang_v[a]   = req_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH];
         neg_in[a]  = ang_v[a][ANGLE_WIDTH-1];
         ang_mag[a] = neg_in[a] ? (~ang_v[a] + 1'b1) : ang_v[a];
         ang_m[a]   = 32'(ang_mag[a]) << ANG_SHIFT;
         cneg_in[a] = ang_m[a] > HALF_PI_Q30;
         r_in[a]    = cneg_in[a] ? (PI_Q30 - ang_m[a]) : ang_m[a];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff     <= r_in;
         neg1_ff  <= neg_in;
         cneg1_ff <= cneg_in;
      end
   end

   // Stage 2: square of the reduced angle.
   logic [PROD_W-1:0] rr_ff [ANGLES];
   logic [31:0]       r2s_ff [ANGLES];
   logic [ANGLES-1:0] neg2_ff, cneg2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < ANGLES; a++) begin
            rr_ff[a]  <= 64'(r_ff[a]) * 64'(r_ff[a]);
            r2s_ff[a] <= r_ff[a];
         end
         neg2_ff  <= neg1_ff;
         cneg2_ff <= cneg1_ff;
      end
   end

   // Stage 3: first series terms and partial sums.
   logic [31:0]   t_ff   [SERIES_STEPS+1][LANES];
   e2q_carry_type car_ff [SERIES_STEPS+1];
   logic [31:0]   t0_in  [LANES];
   e2q_carry_type car0_in;

   always_comb begin
      for (int a = 0; a < ANGLES; a++) begin
         t0_in[2*a]           = r2s_ff[a];
         t0_in[2*a+1]         = Q30_ONE;
         car0_in.acc[2*a]     = ACC_W'(r2s_ff[a]);
         car0_in.acc[2*a+1]   = ACC_W'(Q30_ONE);
         car0_in.r2[a]        = rr_ff[a][Q30_FRAC +: 32];
      end
      car0_in.ang_neg = neg2_ff;
      car0_in.cos_neg = cneg2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0]   <= t0_in;
         car_ff[0] <= car0_in;
      end
   end

   // Series steps: term times r2, divide by k*(k+1) through a reciprocal, then correct.
   for (genvar k = 0; k < SERIES_STEPS; k++) begin : g_step
      localparam logic [8:0]  DV_S  = SIN_DIV[k];
      localparam logic [8:0]  DV_C  = COS_DIV[k];
      localparam logic [31:0] RCP_S = SIN_RCP[k];
      localparam logic [31:0] RCP_C = COS_RCP[k];
      localparam bit          SUB   = (k % 2) == 0;

      logic [PROD_W-1:0] p_ff   [LANES];
      logic [31:0]       x_in   [LANES];
      logic [PROD_W-1:0] qm_in  [LANES];
      logic [31:0]       x_ff   [LANES];
      logic [31:0]       q0_ff  [LANES];
      logic [31:0]       rem_in [LANES];
      logic [31:0]       q_in   [LANES];
      logic [8:0]        dv     [LANES];
      e2q_carry_type     car_a_ff, car_b_ff, car_in;

      // Term product.
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int ln = 0; ln < LANES; ln++) begin
               p_ff[ln] <= 64'(t_ff[k][ln]) * 64'(car_ff[k].r2[ln >> 1]);
            end
            car_a_ff <= car_ff[k];
         end
      end

      // Estimated quotient, at most one below the true one.
      always_comb begin
         for (int ln = 0; ln < LANES; ln++) begin
            x_in[ln]  = p_ff[ln][Q30_FRAC +: 32];
            qm_in[ln] = 64'(x_in[ln]) * 64'(ln[0] ? RCP_C : RCP_S);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int ln = 0; ln < LANES; ln++) begin
               x_ff[ln]  <= x_in[ln];
               q0_ff[ln] <= qm_in[ln][63:32];
            end
            car_b_ff <= car_a_ff;
         end
      end

      // Quotient correction and alternating accumulation.
      always_comb begin
         car_in = car_b_ff;
         for (int ln = 0; ln < LANES; ln++) begin
            dv[ln]     = ln[0] ? DV_C : DV_S;
            rem_in[ln] = x_ff[ln] - 32'(q0_ff[ln] * 32'(dv[ln]));
            q_in[ln]   = q0_ff[ln] + 32'(rem_in[ln] >= 32'(dv[ln]));
            if (SUB) begin
               car_in.acc[ln] = ACC_W'($signed(car_b_ff.acc[ln]) - $signed({2'b00, q_in[ln]}));
            end else begin
               car_in.acc[ln] = ACC_W'($signed(car_b_ff.acc[ln]) + $signed({2'b00, q_in[ln]}));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            t_ff[k+1]   <= q_in;
            car_ff[k+1] <= car_in;
         end
      end
   end

   // Signs of the sines and cosines, then sign and magnitude.
   logic signed [ACC_W-1:0] sig_in [LANES];
   logic signed [ACC_W-1:0] sig_ff [LANES];
   e2q_sm_type              sm_in  [LANES];
   e2q_sm_type              sm_ff  [LANES];

   always_comb begin
      for (int ln = 0; ln < LANES; ln++) begin
         if (ln[0] ? car_ff[SERIES_STEPS].cos_neg[ln >> 1]
                   : car_ff[SERIES_STEPS].ang_neg[ln >> 1]) begin
            sig_in[ln] = -$signed(car_ff[SERIES_STEPS].acc[ln]);
         end else begin
            sig_in[ln] = $signed(car_ff[SERIES_STEPS].acc[ln]);
         end
         sm_in[ln].neg = sig_ff[ln][ACC_W-1];
         sm_in[ln].mag = sm_in[ln].neg ? 32'(-sig_ff[ln]) : 32'(sig_ff[ln]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sig_ff <= sig_in;
         sm_ff  <= sm_in;
      end
   end

   // First product layer: c1c2, s1s2, s1c2, c1s2; bank sine and cosine ride along.
   logic [PROD_W-1:0] l1p_ff [4];
   logic [3:0]        l1n_ff;
   e2q_sm_type        l1c_ff [2];
   e2q_sm_type        l1_in  [4];
   e2q_sm_type        l1_ff  [4];
   e2q_sm_type        l1c2_ff [2];

   always_ff @(posedge clock) begin
      if (adv) begin
         l1p_ff[0] <= 64'(sm_ff[1].mag) * 64'(sm_ff[3].mag);
         l1p_ff[1] <= 64'(sm_ff[0].mag) * 64'(sm_ff[2].mag);
         l1p_ff[2] <= 64'(sm_ff[0].mag) * 64'(sm_ff[3].mag);
         l1p_ff[3] <= 64'(sm_ff[1].mag) * 64'(sm_ff[2].mag);
         l1n_ff    <= {sm_ff[1].neg ^ sm_ff[2].neg, sm_ff[0].neg ^ sm_ff[3].neg,
                       sm_ff[0].neg ^ sm_ff[2].neg, sm_ff[1].neg ^ sm_ff[3].neg};
         l1c_ff[0] <= sm_ff[4];
         l1c_ff[1] <= sm_ff[5];
      end
   end

   // Round the first layer to Q30, halves away from zero.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         l1_in[i].neg = l1n_ff[i];
         l1_in[i].mag = 32'((l1p_ff[i] + (64'd1 << (Q30_FRAC-1))) >> Q30_FRAC);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff   <= l1_in;
         l1c2_ff <= l1c_ff;
      end
   end

   // Second product layer, in the order of the four sums below.
   e2q_sm_type        op_a [8];
   e2q_sm_type        op_b [8];
   logic [PROD_W-1:0] l2p_ff [8];
   logic [7:0]        l2n_ff;

   always_comb begin
      op_a[0] = l1_ff[0]; op_b[0] = l1c2_ff[1];
      op_a[1] = l1_ff[1]; op_b[1] = l1c2_ff[0];
      op_a[2] = l1_ff[0]; op_b[2] = l1c2_ff[0];
      op_a[3] = l1_ff[1]; op_b[3] = l1c2_ff[1];
      op_a[4] = l1_ff[2]; op_b[4] = l1c2_ff[1];
      op_a[5] = l1_ff[3]; op_b[5] = l1c2_ff[0];
      op_a[6] = l1_ff[3]; op_b[6] = l1c2_ff[1];
      op_a[7] = l1_ff[2]; op_b[7] = l1c2_ff[0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 8; i++) begin
            l2p_ff[i] <= 64'(op_a[i].mag) * 64'(op_b[i].mag);
            l2n_ff[i] <= op_a[i].neg ^ op_b[i].neg;
         end
      end
   end

   // Round the second layer and restore signs.
   logic [32:0]             l2m_in [8];
   logic signed [ACC_W-1:0] l2v_in [8];
   logic signed [ACC_W-1:0] l2v_ff [8];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         l2m_in[i] = 33'((l2p_ff[i] + (64'd1 << (Q30_FRAC-1))) >> Q30_FRAC);
         l2v_in[i] = l2n_ff[i] ? -$signed({1'b0, l2m_in[i]}) : $signed({1'b0, l2m_in[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l2v_ff <= l2v_in;
      end
   end

   // Quaternion components w, x, y, z.
   logic signed [ACC_W:0] sum_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff[0] <= (ACC_W+1)'(l2v_ff[0]) - (ACC_W+1)'(l2v_ff[1]);
         sum_ff[1] <= (ACC_W+1)'(l2v_ff[2]) + (ACC_W+1)'(l2v_ff[3]);
         sum_ff[2] <= (ACC_W+1)'(l2v_ff[4]) + (ACC_W+1)'(l2v_ff[5]);
         sum_ff[3] <= (ACC_W+1)'(l2v_ff[6]) - (ACC_W+1)'(l2v_ff[7]);
      end
   end

   // Output magnitude and sign.
   logic [ACC_W:0] om_ff [4];
   logic [3:0]     on_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            on_ff[i] <= sum_ff[i][ACC_W];
            om_ff[i] <= sum_ff[i][ACC_W] ? (ACC_W+1)'(-sum_ff[i]) : (ACC_W+1)'(sum_ff[i]);
         end
      end
   end

   // Round to the output format, saturate to one, apply the sign.
   logic [35:0]           orn_in [4];
   logic [35:0]           osat_in [4];
   logic [OUT_BITS-1:0]   quat_in;
   logic [OUT_BITS-1:0]   quat_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         orn_in[i]  = (36'(om_ff[i]) + OUT_HALF) >> OUT_SHIFT;
         osat_in[i] = (orn_in[i] > OUT_LIMIT) ? OUT_LIMIT : orn_in[i];
         quat_in[i*QUAT_WIDTH +: QUAT_WIDTH] = on_ff[i] ? -QUAT_WIDTH'(osat_in[i])
                                                        : QUAT_WIDTH'(osat_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quat_ff <= quat_in;
      end
   end

   assign rsp_tdata = OUT_W'(quat_ff);

   // Range check of the held result.
   logic                         out_ok;
   logic signed [QUAT_WIDTH:0]   ofx [4];

   always_comb begin
      out_ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
         ofx[i] = $signed({quat_ff[i*QUAT_WIDTH + QUAT_WIDTH-1],
                           quat_ff[i*QUAT_WIDTH +: QUAT_WIDTH]});
         out_ok = out_ok && (ofx[i] <= OUT_LIM_S) && (ofx[i] >= -OUT_LIM_S);
      end
   end

   `E2Q_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, vld_ff[0])
   `E2Q_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld_ff))
   `E2Q_ASSERT_NOW(a_unit_range, rsp_tvalid, out_ok)

endmodule

`default_nettype wire
